FILE: src/utf8vs_pkg.sv
// Package with types, constants and helper functions for the UTF-8 validate/sanitize block.
package utf8vs_pkg;

  // Default depth of the job queue between the classifier and the serializer.
  localparam int QUEUE_DEPTH = 2;

  // Replacement byte after reset ('?').
  localparam logic [7:0] REPL_RESET = 8'h3F;

  // Largest number of result bytes that one input byte can cause.
  localparam int MAX_OUT = 4;

  // Lead byte classes, given as the full sequence length.
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_ONE = 3'd1;
  localparam logic [2:0] LEN_TWO = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // Code point limits.
  localparam logic [20:0] CP_MIN_TWO = 21'h00080;
  localparam logic [20:0] CP_MIN_THREE = 21'h00800;
  localparam logic [20:0] CP_MIN_FOUR = 21'h10000;
  localparam logic [20:0] CP_SURR_LO = 21'h0D800;
  localparam logic [20:0] CP_SURR_HI = 21'h0DFFF;
  localparam logic [20:0] CP_MAX = 21'h10FFFF;

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       out_last;
    logic       string_valid;
  } out_item_t;

  // All results caused by one input byte, oldest in slot 0.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] data;
    logic [MAX_OUT-1:0]      repl;
    logic [2:0]              count;
    logic                    last;
    logic                    valid;
  } job_t;

  // Sequence length announced by a lead byte, LEN_BAD for invalid leads.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    begin
      if (b[7] == 1'b0) len = LEN_ONE;
      else if (b[7:5] == 3'b110) len = LEN_TWO;
      else if (b[7:4] == 4'b1110) len = LEN_THREE;
      else if (b[7:3] == 5'b11110) len = LEN_FOUR;
      else len = LEN_BAD;
      return len;
    end
  endfunction

  // Range check of a complete sequence; b_last is its final byte.
  function automatic logic value_ok(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b_last,
                                    input logic [2:0] len);
    logic [20:0] cp;
    logic        ok;
    begin
      case (len)
        LEN_TWO: begin
          cp = {10'd0, b0[4:0], b_last[5:0]};
          ok = (cp >= CP_MIN_TWO);
        end
        LEN_THREE: begin
          cp = {5'd0, b0[3:0], b1[5:0], b_last[5:0]};
          ok = (cp >= CP_MIN_THREE) && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
        end
        LEN_FOUR: begin
          cp = {b0[2:0], b1[5:0], b2[5:0], b_last[5:0]};
          ok = (cp >= CP_MIN_FOUR) && (cp <= CP_MAX);
        end
        default: begin
          cp = '0;
          ok = 1'b0;
        end
      endcase
      return ok;
    end
  endfunction

endpackage

FILE: src/utf8vs_front.sv
// Front part: accepts bytes, tracks the pending sequence and builds one result job per byte.
module utf8vs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  utf8vs_pkg::in_item_t in_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output logic                job_push,
  output utf8vs_pkg::job_t    job
);
  import utf8vs_pkg::*;

  logic [7:0] repl_byte;
  logic [7:0] pend [3];
  logic [1:0] pcnt, pcnt_next;
  logic [2:0] exp_len, exp_next;
  logic       err, err_next;
  logic       lead_store, cont_store;

  logic [7:0] b;
  logic       last;
  logic       is_cont;
  logic [2:0] total;
  logic [2:0] len;
  logic [7:0] s1, s2;
  logic       ok;
  logic [1:0] k;

  assign b = in_item.in_byte;
  assign last = in_item.in_last;
  assign is_cont = (b[7:6] == 2'b10);
  assign cfg_ready = 1'b1;

  // Classify the byte and fill the result slots.
  always_comb begin
    job = '0;
    pcnt_next = pcnt;
    exp_next = exp_len;
    lead_store = 1'b0;
    cont_store = 1'b0;
    total = {1'b0, pcnt} + 3'd1;
    len = lead_len(b);
    s1 = (total == LEN_TWO) ? b : pend[1];
    s2 = (total == LEN_THREE) ? b : pend[2];
    ok = 1'b0;
    k = pcnt;
    if ((pcnt != 2'd0) && is_cont) begin
      if ((total >= exp_len) || (pcnt == 2'd3)) begin
        // Sequence complete: copy it or replace all of it.
        ok = (total == exp_len) && value_ok(pend[0], pend[1], pend[2], b, total);
        for (int i = 0; i < MAX_OUT; i++) begin
          if (3'(i) < total) begin
            job.repl[i] = !ok;
            if (!ok) job.data[i] = repl_byte;
            else if (i == 0) job.data[i] = pend[0];
            else if (i == 1) job.data[i] = s1;
            else if (i == 2) job.data[i] = s2;
            else job.data[i] = b;
          end
        end
        job.count = total;
        pcnt_next = 2'd0;
        exp_next = 3'd0;
      end else begin
        // Hold the continuation; on the final byte the whole sequence is truncated.
        cont_store = 1'b1;
        pcnt_next = pcnt + 2'd1;
        if (last) begin
          for (int i = 0; i < MAX_OUT; i++) begin
            if (3'(i) < total) begin
              job.data[i] = repl_byte;
              job.repl[i] = 1'b1;
            end
          end
          job.count = total;
        end
      end
    end else begin
      // Any held bytes are broken by this byte.
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pcnt) begin
          job.data[i] = repl_byte;
          job.repl[i] = 1'b1;
        end
      end
      pcnt_next = 2'd0;
      exp_next = 3'd0;
      job.count = {1'b0, k};
      if (len == LEN_ONE) begin
        job.data[k] = b;
        job.count = {1'b0, k} + 3'd1;
      end else if (len == LEN_BAD) begin
        job.data[k] = repl_byte;
        job.repl[k] = 1'b1;
        job.count = {1'b0, k} + 3'd1;
      end else begin
        lead_store = 1'b1;
        pcnt_next = 2'd1;
        exp_next = len;
        if (last) begin
          job.data[k] = repl_byte;
          job.repl[k] = 1'b1;
          job.count = {1'b0, k} + 3'd1;
        end
      end
    end
    // The final byte ends the string and reports its validity.
    err_next = err | (|job.repl);
    if (last) begin
      pcnt_next = 2'd0;
      exp_next = 3'd0;
      job.last = 1'b1;
      job.valid = !err_next;
      err_next = 1'b0;
    end
  end

  assign job_push = accept && (job.count != 3'd0);

  // Sequence state and the replacement register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= 2'd0;
      exp_len <= 3'd0;
      err <= 1'b0;
      repl_byte <= REPL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        repl_byte <= cfg_data;
      end
      if (accept) begin
        pcnt <= pcnt_next;
        exp_len <= exp_next;
        err <= err_next;
      end
    end
  end

  // Held bytes carry no reset.
  always_ff @(posedge clk) begin
    if (accept && lead_store) begin
      pend[0] <= b;
    end
    if (accept && cont_store) begin
      case (pcnt)
        2'd1: pend[1] <= b;
        2'd2: pend[2] <= b;
        default: pend[0] <= pend[0];
      endcase
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> (pcnt == 2'd0) && !err)
    else $error("pending state not cleared after final byte");

  a_pend_shorter: assert property (@(posedge clk) disable iff (rst)
    (pcnt != 2'd0) |-> (exp_len >= LEN_TWO) && (exp_len > {1'b0, pcnt}))
    else $error("pending count does not fit expected length");

endmodule

FILE: src/utf8vs_queue.sv
// Short job queue between the classifier and the serializer.
module utf8vs_queue #(
  parameter int DEPTH = utf8vs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  utf8vs_pkg::job_t wr_data,
  output logic             full,
  input  logic             rd,
  output utf8vs_pkg::job_t rd_data,
  output logic             empty
);
  import utf8vs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rd_data = mem[rptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (wr && !rd) count <= count + CW'(1);
      else if (rd && !wr) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (count < CW'(DEPTH)) || rd)
    else $error("job queue overflow");

endmodule

FILE: src/utf8vs_back.sv
// Back part: takes jobs from the queue and hands out their bytes one transfer at a time.
module utf8vs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  utf8vs_pkg::job_t     q_data,
  output logic                 q_rd,
  output logic                 empty,
  input  logic                 pop,
  output utf8vs_pkg::out_item_t out_item
);
  import utf8vs_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       at_end;
  logic       advance;

  assign at_end = ({1'b0, idx} == (cur.count - 3'd1));
  assign advance = !busy || (pop && at_end);
  assign q_rd = advance && !q_empty;
  assign empty = !busy;

  // Present the current slot.
  always_comb begin
    out_item.out_byte = cur.data[idx];
    out_item.was_replaced = cur.repl[idx];
    out_item.out_last = cur.last && at_end;
    out_item.string_valid = cur.last && at_end && cur.valid;
  end

  // Job holding register and slot counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= 2'd0;
    end else if (advance) begin
      busy <= !q_empty;
      idx <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur.count != 3'd0) && ({1'b0, idx} < cur.count))
    else $error("slot index outside the current job");

endmodule

FILE: src/utf8_validate_sanitize.sv
// Top level of the UTF-8 validator and sanitizer.
// Bytes enter through a queue-like port (push/full) and results leave through
// another (empty/pop). A classifier turns each accepted byte into a job of zero
// to four result bytes, a queue of QUEUE_DEPTH jobs decouples it from the
// serializer, and the serializer hands out one result byte per cycle while pop
// is held. A plain stream runs at one byte per cycle; a byte that yields several
// results holds the output while they are handed out, and input stalls only once
// the job queue fills. When the serializer is idle, the first result of a byte
// passes through the queue storage and the serializer's job register before it
// appears. No clearing pass follows reset.
module utf8_validate_sanitize #(
  parameter int QUEUE_DEPTH = utf8vs_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  utf8vs_pkg::in_item_t  in_item,
  output logic                  empty,
  input  logic                  pop,
  output utf8vs_pkg::out_item_t out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);
  import utf8vs_pkg::*;

  job_t job, q_data;
  logic job_push, q_rd, q_empty, accept;

  assign accept = push && !full;

  utf8vs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (in_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .job_push (job_push),
    .job      (job)
  );

  utf8vs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_data(job),
    .full   (full),
    .rd     (q_rd),
    .rd_data(q_data),
    .empty  (q_empty)
  );

  utf8vs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

endmodule

FILE: test/tb.sv
// Self-checking testbench for the UTF-8 validator and sanitizer.
module tb;
  import utf8vs_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_BYTES = 72;

  // Shadow copy of the sanitizer: tracks the held sequence and queues the
  // result bytes that each accepted input byte must produce.
  class utf8_shadow;
    logic [7:0] repl_byte;
    logic [7:0] held [3];
    int unsigned held_n;
    int unsigned want_len;
    bit err;
    out_item_t exp_q[$];
    int unsigned errors, n_in, n_out, n_repl, n_str;

    function new();
      repl_byte = REPL_RESET;
      held_n = 0;
      want_len = 0;
      err = 0;
      errors = 0;
      n_in = 0;
      n_out = 0;
      n_repl = 0;
      n_str = 0;
    endfunction

    function void emit(logic [7:0] b, bit r);
      out_item_t o;
      o.out_byte = b;
      o.was_replaced = r;
      o.out_last = 1'b0;
      o.string_valid = 1'b0;
      exp_q.push_back(o);
      if (r) begin
        err = 1;
        n_repl++;
      end
    endfunction

    function logic [2:0] seq_len_of(logic [7:0] b);
      if (!b[7]) return LEN_ONE;
      if (b[7:5] == 3'b110) return LEN_TWO;
      if (b[7:4] == 4'b1110) return LEN_THREE;
      if (b[7:3] == 5'b11110) return LEN_FOUR;
      return LEN_BAD;
    endfunction

    // Code point range check of a complete sequence.
    function bit in_range(logic [3:0][7:0] s, int unsigned n);
      logic [20:0] cp;
      if (n == 2) begin
        cp = {10'd0, s[0][4:0], s[1][5:0]};
        return cp >= CP_MIN_TWO;
      end
      if (n == 3) begin
        cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
        return cp >= CP_MIN_THREE && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
      end
      cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
      return cp >= CP_MIN_FOUR && cp <= CP_MAX;
    endfunction

    function void flush_held();
      for (int k = 0; k < held_n; k++) emit(repl_byte, 1'b1);
      held_n = 0;
      want_len = 0;
    endfunction

    function void take(logic [7:0] b);
      logic [3:0][7:0] s;
      logic [2:0] len;
      int unsigned total;
      if (held_n > 0) begin
        if (b[7:6] == 2'b10) begin
          if (held_n + 1 >= want_len) begin
            s = '0;
            for (int k = 0; k < held_n; k++) s[k] = held[k];
            s[held_n] = b;
            total = held_n + 1;
            if (total == want_len && in_range(s, total)) begin
              for (int k = 0; k < total; k++) emit(s[k], 1'b0);
            end else begin
              for (int k = 0; k < total; k++) emit(repl_byte, 1'b1);
            end
            held_n = 0;
            want_len = 0;
          end else begin
            held[held_n] = b;
            held_n++;
          end
          return;
        end
        // A non-continuation breaks the held sequence.
        flush_held();
      end
      len = seq_len_of(b);
      if (len == LEN_ONE) emit(b, 1'b0);
      else if (len == LEN_BAD) emit(repl_byte, 1'b1);
      else begin
        held[0] = b;
        held_n = 1;
        want_len = len;
      end
    endfunction

    // Notes one accepted input byte and queues its expected results.
    function void note_byte(in_item_t it);
      out_item_t o;
      n_in++;
      take(it.in_byte);
      if (it.in_last) begin
        flush_held();
        o = exp_q.pop_back();
        o.out_last = 1'b1;
        o.string_valid = !err;
        exp_q.push_back(o);
        err = 0;
        n_str++;
      end
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_out(out_item_t got);
      out_item_t want;
      n_out++;
      if (exp_q.size() == 0) begin
        $error("unexpected result: out_byte %h", got.out_byte);
        errors++;
        return;
      end
      want = exp_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.was_replaced !== want.was_replaced) begin
        $error("was_replaced: expected %b, got %b", want.was_replaced, got.was_replaced);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %b, got %b", want.out_last, got.out_last);
        errors++;
      end
      if (got.string_valid !== want.string_valid) begin
        $error("string_valid: expected %b, got %b", want.string_valid, got.string_valid);
        errors++;
      end
    endfunction
  endclass

  typedef enum int {
    CH_ASCII, CH_VALID, CH_OVERLONG, CH_SURROGATE, CH_HIGH, CH_TRUNC, CH_BAD_LEAD,
    CH_STRAY, CH_RAW
  } char_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  utf8_shadow sb = new();

  logic [7:0] str_buf[$];
  int unsigned sent = 0;
  int unsigned n_cfg = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit quiet = 0;
  bit flood = 0;
  bit hold_req = 0;
  int unsigned idle_cycles = 0;

  utf8_validate_sanitize u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor both sides at the clock edge.
  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_byte(in_item);
    if (!rst && pop && !empty) sb.check_out(out_item);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: pop bursts, random idle bursts and one long hold-off.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offers one byte and waits for its transfer; push stays high afterward.
  task automatic put_byte(logic [7:0] b, bit last);
    in_item_t v;
    if (!quiet && !flood && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    v.in_byte = b;
    v.in_last = last;
    push <= 1'b1;
    in_item <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_buf.size(); i++) put_byte(str_buf[i], i == str_buf.size() - 1);
  endtask

  // Stops input and waits until every expected result has been taken.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_repl(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.repl_byte = v;
    n_cfg++;
  endtask

  // Appends the first keep bytes of the n-byte form of cp, overlong or not.
  task automatic push_enc(logic [20:0] cp, int unsigned n, int unsigned keep);
    logic [3:0][7:0] e;
    case (n)
      2: e = {16'h0, 8'h80 | cp[5:0], 8'hC0 | cp[10:6]};
      3: e = {8'h0, 8'h80 | cp[5:0], 8'h80 | cp[11:6], 8'hE0 | cp[15:12]};
      default: e = {8'h80 | cp[5:0], 8'h80 | cp[11:6], 8'h80 | cp[17:12], 8'hF0 | cp[20:18]};
    endcase
    for (int k = 0; k < keep; k++) str_buf.push_back(e[k]);
  endtask

  function automatic logic [20:0] pick_valid_cp(int unsigned n);
    logic [20:0] cp;
    bit edge_pick;
    edge_pick = ($urandom_range(0, 3) == 0);
    if (n == 2) begin
      cp = edge_pick ? ($urandom_range(0, 1) ? 21'h7FF : 21'h080)
                     : 21'($urandom_range(21'h80, 21'h7FF));
    end else if (n == 3) begin
      if (edge_pick) begin
        case ($urandom_range(0, 3))
          0: cp = 21'h0800;
          1: cp = 21'h0FFFF;
          2: cp = 21'h0D7FF;
          default: cp = 21'h0E000;
        endcase
      end else begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp ^ 21'h4000;
      end
    end else begin
      cp = edge_pick ? ($urandom_range(0, 1) ? CP_MAX : CP_MIN_FOUR)
                     : 21'($urandom_range(21'h10000, 21'h10FFFF));
    end
    return cp;
  endfunction

  // Builds a random string: mostly well-formed characters, some broken ones.
  task automatic build_string(int unsigned nchars);
    char_kind_e kind;
    int unsigned w, n;
    str_buf.delete();
    for (int c = 0; c < nchars; c++) begin
      w = $urandom_range(0, 99);
      if (w < 35) kind = CH_ASCII;
      else if (w < 70) kind = CH_VALID;
      else kind = char_kind_e'($urandom_range(CH_OVERLONG, CH_RAW));
      n = $urandom_range(2, 4);
      case (kind)
        CH_ASCII: str_buf.push_back(8'($urandom_range(8'h00, 8'h7F)));
        CH_VALID: push_enc(pick_valid_cp(n), n, n);
        CH_OVERLONG: begin
          if (n == 2) push_enc(21'($urandom_range(0, 21'h7F)), 2, 2);
          else if (n == 3) push_enc(21'($urandom_range(0, 21'h7FF)), 3, 3);
          else push_enc(21'($urandom_range(0, 21'hFFFF)), 4, 4);
        end
        CH_SURROGATE: push_enc(21'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3, 3);
        CH_HIGH: push_enc(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
        CH_TRUNC: push_enc(pick_valid_cp(n), n, $urandom_range(1, n - 1));
        CH_BAD_LEAD: str_buf.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        CH_STRAY: str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        default: str_buf.push_back(8'($urandom_range(8'h00, 8'hFF)));
      endcase
    end
  endtask

  initial begin
    logic [7:0] repl_plan [PHASES];
    int unsigned target;
    repl_plan[0] = 8'h00;
    repl_plan[1] = 8'hFF;
    repl_plan[2] = 8'($urandom_range(0, 255));
    repl_plan[3] = 8'h80;
    repl_plan[4] = REPL_RESET;
    repl_plan[5] = 8'($urandom_range(0, 255));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed strings with the reset replacement byte.
    recv_idle_pct = 20;
    send_idle_pct = 20;
    // Byte zero alone.
    str_buf = '{8'h00};
    send_string();
    // Shortest valid two-byte sequence.
    str_buf = '{8'hC2, 8'h80};
    send_string();
    // Invalid lead followed by a stray continuation.
    str_buf = '{8'hFF, 8'h80};
    send_string();
    // Overlong three-byte form.
    str_buf = '{8'hE0, 8'h80, 8'h80};
    send_string();
    // Surrogate.
    str_buf = '{8'hED, 8'hA0, 8'h80};
    send_string();
    // Value above the largest code point.
    str_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_string();
    // Valid four-byte sequence.
    str_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_string();
    // Sequence broken by an ASCII byte.
    str_buf = '{8'hE2, 8'h82, 8'h41};
    send_string();
    // Three held bytes broken by a lead that is truncated at the end.
    str_buf = '{8'hF0, 8'h9F, 8'h98, 8'hE0};
    send_string();
    // Overlong two-byte form.
    str_buf = '{8'hC0, 8'h80};
    send_string();

    // Random phases, each with its own replacement byte and idle mix.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_repl(repl_plan[p]);
      send_idle_pct = (p == 0) ? 0 : $urandom_range(10, 40);
      recv_idle_pct = (p == 0) ? 0 : $urandom_range(10, 40);
      quiet = (p == PHASES - 1);
      if (p == 2) begin
        // The receiver holds off while input keeps coming, so the block fills.
        flood = 1;
        hold_req = 1;
      end
      target = sent + PHASE_BYTES;
      while (sent < target) begin
        build_string($urandom_range(1, 8));
        send_string();
      end
      flood = 0;
    end

    settle();
    $display("covered %0d bytes in %0d strings, %0d results (%0d replaced)",
             sb.n_in, sb.n_str, sb.n_out, sb.n_repl);
    $display("replacement byte set %0d times, one long result stall", n_cfg);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
